>>> rtl/adlb_pkg.sv
// Shared types and character constants for the ASCII decimal to display bridge.
`default_nettype none
package adlb_pkg;

    // Most result beats one received character can cause
    localparam int MAX_RESULTS = 6;
    localparam int RES_CNT_W   = 3;

    // ASCII codes the bridge reacts to or sends
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_DATA    = 8'h64;
    localparam logic [7:0] CH_CMD     = 8'h63;
    localparam logic [7:0] CH_TAKEN   = 8'h74;
    localparam logic [7:0] CH_REFUSED = 8'h6E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    // Result kind codes
    localparam logic KIND_SERIAL  = 1'b0;
    localparam logic KIND_DISPLAY = 1'b1;

    // Display write modes
    localparam logic MODE_CMD  = 1'b0;
    localparam logic MODE_DATA = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic       mode;
        logic       last;
    } entry_t;

    typedef entry_t [MAX_RESULTS-1:0] entry_list_t;

endpackage
`default_nettype wire

>>> rtl/adlb_decode.sv
// Character decoder: next digit state and the list of result beats for one byte.
`default_nettype none
module adlb_decode #(
    parameter int NUM_DIGITS = 3
) (
    input  logic [7:0]                  rx_byte,
    input  logic [1:0]                  digit_count,
    input  logic [NUM_DIGITS-1:0][3:0]  digit_store,
    input  logic                        data_mode,
    output logic [1:0]                  digit_count_next,
    output logic [NUM_DIGITS-1:0][3:0]  digit_store_next,
    output logic                        data_mode_next,
    output adlb_pkg::entry_list_t       list,
    output logic [adlb_pkg::RES_CNT_W-1:0] list_len
);
    import adlb_pkg::*;

    always_comb
    begin
        logic [7:0]           mode_letter;
        logic [9:0]           value;
        logic [RES_CNT_W-1:0] idx;

        digit_count_next = digit_count;
        digit_store_next = digit_store;
        data_mode_next   = data_mode;
        list             = '0;
        idx              = '0;
        value            = '0;
        mode_letter      = data_mode ? CH_DATA : CH_CMD;

        if (rx_byte == CH_CR)
        begin
            digit_store_next = '0;
            digit_count_next = 2'd0;
            list[0] = '{KIND_SERIAL, CH_CR, MODE_CMD, 1'b0};
            list[1] = '{KIND_SERIAL, mode_letter, MODE_CMD, 1'b0};
            idx     = 3'd2;
        end
        else if (rx_byte == CH_DATA)
        begin
            data_mode_next = MODE_DATA;
        end
        else if (rx_byte == CH_CMD)
        begin
            data_mode_next = MODE_CMD;
        end
        else if (rx_byte >= CH_ZERO && rx_byte <= CH_NINE)
        begin
            // store and echo while there is room
            if (digit_count < 2'(NUM_DIGITS))
            begin
                for (int i = 0; i < NUM_DIGITS; i++)
                begin
                    if (digit_count == 2'(i))
                    begin
                        digit_store_next[i] = 4'(rx_byte - CH_ZERO);
                    end
                end
                digit_count_next = 2'(digit_count + 2'd1);
                list[idx] = '{KIND_SERIAL, rx_byte, MODE_CMD, 1'b0};
                idx       = 3'(idx + 3'd1);
            end
            // full: convert the held digits, most significant first
            if (digit_count_next >= 2'(NUM_DIGITS))
            begin
                for (int i = 0; i < NUM_DIGITS; i++)
                begin
                    value = 10'((value << 3) + (value << 1)) + {6'd0, digit_store_next[i]};
                end
                if (value < 10'd256)
                begin
                    list[idx] = '{KIND_SERIAL, CH_TAKEN, MODE_CMD, 1'b0};
                    idx       = 3'(idx + 3'd1);
                    list[idx] = '{KIND_SERIAL, value[7:0], MODE_CMD, 1'b0};
                    idx       = 3'(idx + 3'd1);
                    list[idx] = '{KIND_DISPLAY, value[7:0], data_mode, 1'b0};
                    idx       = 3'(idx + 3'd1);
                end
                else
                begin
                    list[idx] = '{KIND_SERIAL, CH_REFUSED, MODE_CMD, 1'b0};
                    idx       = 3'(idx + 3'd1);
                end
                list[idx] = '{KIND_SERIAL, CH_CR, MODE_CMD, 1'b0};
                idx       = 3'(idx + 3'd1);
                list[idx] = '{KIND_SERIAL, mode_letter, MODE_CMD, 1'b0};
                idx       = 3'(idx + 3'd1);
                digit_count_next = 2'd0;
            end
        end

        if (idx != '0)
        begin
            list[3'(idx - 3'd1)].last = 1'b1;
        end
        list_len = idx;
    end

endmodule
`default_nettype wire

>>> rtl/ascii_decimal_to_lcd_bridge_core.sv
// Top level of the ASCII decimal to display bridge: stream ports, digit state, result queue.
`default_nettype none
// Received serial characters arrive one per slave beat. A carriage return
// clears the digit store and answers CR plus the mode letter ('c' or 'd');
// 'c' and 'd' switch between command and data mode silently; digits '0'..'9'
// are stored and echoed. When NUM_DIGITS digits are held the value is
// formed: below 256 the bridge sends 't', the value, and one display write in
// the current mode, otherwise 'n'; then CR and the mode letter. After reset
// the digit count reads full, so the first digit before any CR triggers a
// conversion of zeros instead of being stored. Every other byte is dropped.
// Timing: a character is decoded in the cycle it is accepted and its results
// are loaded into a six-entry output queue; the queue drives one result beat
// per cycle from a register while the master side is ready. A character with
// results (at most 6) holds the slave side until its last result beat is
// taken, and a character with no result leaves the slave side ready. The next
// character is accepted in the same cycle that the last result beat of the
// previous one is taken, so the slave side waits until the final queued
// beat is taken, and any stall on the master side delays the next character.
module ascii_decimal_to_lcd_bridge_core #(
    parameter int NUM_DIGITS = 3
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [0] out_kind, [1] display_data_mode
    output logic       m_tlast    // last result of this character
);
    import adlb_pkg::*;

    // digit state
    logic [1:0]                 digit_count_reg, digit_count_next;
    logic [NUM_DIGITS-1:0][3:0] digit_store_reg, digit_store_next;
    logic                       data_mode_reg, data_mode_next;

    // result queue: entry 0 is the beat on the master side
    entry_list_t                res_reg, res_next;
    logic [RES_CNT_W-1:0]       res_cnt_reg, res_cnt_next;

    entry_list_t                dec_list;
    logic [RES_CNT_W-1:0]       dec_len;
    logic                       in_beat, out_beat;

    adlb_decode #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_decode (
        .rx_byte          (s_tdata),
        .digit_count      (digit_count_reg),
        .digit_store      (digit_store_reg),
        .data_mode        (data_mode_reg),
        .digit_count_next (digit_count_next),
        .digit_store_next (digit_store_next),
        .data_mode_next   (data_mode_next),
        .list             (dec_list),
        .list_len         (dec_len)
    );

    // take a new character when the queue is empty or its final beat leaves now
    assign s_tready = (res_cnt_reg == '0) || (res_cnt_reg == 3'd1 && m_tready);
    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    assign m_tvalid = (res_cnt_reg != '0);
    assign m_tdata  = res_reg[0].data_byte;
    assign m_tuser  = {res_reg[0].mode, res_reg[0].kind};
    assign m_tlast  = res_reg[0].last;

    // load the fresh list on a new character, otherwise advance on a taken beat
    always_comb
    begin
        res_next     = res_reg;
        res_cnt_next = res_cnt_reg;
        if (in_beat)
        begin
            res_next     = dec_list;
            res_cnt_next = dec_len;
        end
        else if (out_beat)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                res_next[i] = res_reg[i+1];
            end
            res_cnt_next = 3'(res_cnt_reg - 3'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_count_reg <= 2'(NUM_DIGITS);
            digit_store_reg <= '0;
            data_mode_reg   <= MODE_CMD;
            res_cnt_reg     <= '0;
        end
        else
        begin
            res_cnt_reg <= res_cnt_next;
            if (in_beat)
            begin
                digit_count_reg <= digit_count_next;
                digit_store_reg <= digit_store_next;
                data_mode_reg   <= data_mode_next;
            end
        end
    end

    // payload: no reset needed
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        digit_count_reg <= 2'(NUM_DIGITS))
        else $error("digit count beyond digit store");

    a_queue_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_cnt_reg <= 3'(MAX_RESULTS))
        else $error("result queue overfilled");

    a_last_marks_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (res_cnt_reg == 3'd1)))
        else $error("tlast does not mark the final queued beat");

    a_serial_mode_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0] == KIND_SERIAL) |-> (m_tuser[1] == MODE_CMD))
        else $error("serial beat carries a display mode");
`endif

endmodule
`default_nettype wire
